@@ hw/rtl/bez_pkg.sv @@
// Shared types and fixed-point constants for the Bezier easing block.
package bez_pkg;

   // Q1.15 interface format and the internal Q.24 format
   localparam int unsigned Q15_W       = 16;
   localparam int unsigned Q15_SHIFT   = 9;
   localparam int unsigned FRAC_BITS   = 24;

   // Internal widths, sized from the value ranges the curve can reach
   localparam int unsigned T_W         = 27;
   localparam int unsigned DATA_W      = 34;
   localparam int unsigned MUL_A_W     = 33;
   localparam int unsigned MUL_B_W     = 29;
   localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic [Q15_W-1:0]         Q15_ONE     = 16'd32768;
   localparam logic signed [DATA_W-1:0] Q15_ONE_D   = 34'sd32768;
   localparam logic signed [DATA_W-1:0] ONE_Q24     = 34'sd16777216;
   localparam logic signed [DATA_W-1:0] EPS_Q24     = 34'sd8389;
   localparam logic signed [DATA_W-1:0] T_LIMIT_Q24 = 34'sd33554432;
   localparam logic signed [DATA_W-1:0] Y_ROUND     = 34'sd256;
   localparam logic signed [PROD_W-1:0] MUL_BIAS    = 62'sd8388608;

   typedef struct packed {
      logic [Q15_W-1:0] progress_x;
      logic [Q15_W-1:0] first_ctrl_x;
      logic [Q15_W-1:0] first_ctrl_y;
      logic [Q15_W-1:0] second_ctrl_x;
      logic [Q15_W-1:0] second_ctrl_y;
   } req_payload_type;

   typedef struct packed {
      logic [Q15_W-1:0] eased_y;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_K0,
      ST_ADD_K1,
      ST_MUL_P1,
      ST_ADD_K2,
      ST_MUL_P2,
      ST_CHECK,
      ST_Y_TT,
      ST_Y_RR,
      ST_Y_T2T,
      ST_Y_T2R,
      ST_Y_BY,
      ST_Y_TR2,
      ST_Y_AY,
      ST_Y_SUM,
      ST_OUT
   } state_type;

endpackage

@@ hw/rtl/bez_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
interface bez_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/bezier_easing_y_from_x.sv @@
// Cubic Bezier easing: eased y for a progress x, one shared multiplier under a sequencer.
//
// Takes one request beat at a time (req_bus.ready is high only when idle) and returns one
// response beat per request. When both control points sit on the diagonal the response is
// x itself (capped at 1.0), going straight to the output step. Otherwise the block runs a
// damped solve for the curve parameter, each round being three multiplies through the
// single 33x29 multiplier, the first two each followed by a round-and-add step and the
// third by the residual check and damped update, for 1 to ITERATIONS rounds (default 12);
// then the y cubic and output saturation follow, all through the same shared multiplier. A
// finished result waits in the output register, so the next request is taken while it is
// still pending; a result only stalls the block if the previous one has not been taken.
module bezier_easing_y_from_x
   import bez_pkg::*;
#(
   parameter int unsigned ITERATIONS = 12
) (
   input logic          clock,
   input logic          reset,
   bez_stream_if.sink   req_bus,
   bez_stream_if.source rsp_bus
);

   localparam int unsigned CNT_W = $clog2(ITERATIONS + 1);
   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ITERATIONS - 1);
   localparam logic signed [DATA_W-1:0] D_ONE = 34'sd1;

   // control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // operand and working registers
   logic [Q15_W-1:0]         x_ff, x_in;
   logic                     diag_ff, diag_in;
   logic signed [DATA_W-1:0] k0_ff, k0_in, k1_ff, k1_in, k2_ff, k2_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [MUL_B_W-1:0] ay3_ff, ay3_in, by3_ff, by3_in;
   logic signed [T_W-1:0]    t_ff, t_in, r_ff, r_in;
   logic signed [DATA_W-1:0] s_ff, s_in, p_ff, p_in;
   logic signed [DATA_W-1:0] t2_ff, t2_in, r2_ff, r2_in, y_ff, y_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [Q15_W-1:0]         rsp_data_ff, rsp_data_in;

   // shared multiplier and helpers
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_shift;
   logic signed [DATA_W-1:0]  rnd;
   logic signed [DATA_W-1:0]  ax, ay, bx, by, xq_new, xq, t_ext;
   logic signed [DATA_W-1:0]  diff, half, t_clamp, y_scaled;
   logic [Q15_W-1:0]          result;
   logic                      converged;

   // shared multiply with the rounding bias folded in; rounded Q.24 value of the last product
   assign prod_in    = mul_a * mul_b + MUL_BIAS;
   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign rnd        = $signed(prod_shift[DATA_W-1:0]);

   // request fields widened to the working format
   assign ax     = $signed(DATA_W'(req_bus.payload.first_ctrl_x));
   assign ay     = $signed(DATA_W'(req_bus.payload.first_ctrl_y));
   assign bx     = $signed(DATA_W'(req_bus.payload.second_ctrl_x));
   assign by     = $signed(DATA_W'(req_bus.payload.second_ctrl_y));
   assign xq_new = $signed(DATA_W'({req_bus.payload.progress_x, {Q15_SHIFT{1'b0}}}));
   assign xq     = $signed(DATA_W'({x_ff, {Q15_SHIFT{1'b0}}}));
   assign t_ext  = DATA_W'(t_ff);

   // residual test and damped update: s holds 2t + x + 1, so (s - X(t)) / 2 floored is the new t
   assign converged = (rnd >= lo_ff) && (rnd <= hi_ff);
   assign diff      = s_ff - rnd;
   assign half      = diff >>> 1;
   always_comb begin
      if (half > T_LIMIT_Q24) begin
         t_clamp = T_LIMIT_Q24;
      end else if (half < -T_LIMIT_Q24) begin
         t_clamp = -T_LIMIT_Q24;
      end else begin
         t_clamp = half;
      end
   end

   // output rounding back to Q1.15 and saturation
   assign y_scaled = (y_ff + Y_ROUND) >>> Q15_SHIFT;
   always_comb begin
      if (diag_ff) begin
         result = (x_ff > Q15_ONE) ? Q15_ONE : x_ff;
      end else if (y_scaled < 0) begin
         result = '0;
      end else if (y_scaled > Q15_ONE_D) begin
         result = Q15_ONE;
      end else begin
         result = y_scaled[Q15_W-1:0];
      end
   end

   // sequencer: next state, operand select and register updates
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      diag_in      = diag_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ay3_in       = ay3_ff;
      by3_in       = by3_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      t2_in        = t2_ff;
      r2_in        = r2_ff;
      y_in         = y_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = $signed(k0_ff[MUL_A_W-1:0]);
      mul_b        = MUL_B_W'(t_ff);

      // response beat taken
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               x_in    = req_bus.payload.progress_x;
               diag_in = (ax == ay) && (bx == by);
               k0_in   = (Q15_ONE_D + ax + (ax <<< 1) - bx - (bx <<< 1)) <<< Q15_SHIFT;
               k1_in   = (bx + (bx <<< 1) - (ax <<< 2) - (ax <<< 1)) <<< Q15_SHIFT;
               k2_in   = (ax + (ax <<< 1)) <<< Q15_SHIFT;
               lo_in   = xq_new - EPS_Q24;
               hi_in   = xq_new + EPS_Q24;
               ay3_in  = $signed(MUL_B_W'((ay + (ay <<< 1)) <<< Q15_SHIFT));
               by3_in  = $signed(MUL_B_W'((by + (by <<< 1)) <<< Q15_SHIFT));
               t_in    = $signed(xq_new[T_W-1:0]);
               cnt_in  = '0;
               state_in = diag_in ? ST_OUT : ST_MUL_K0;
            end
         end
         ST_MUL_K0: begin
            mul_a    = $signed(k0_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(t_ff);
            s_in     = (t_ext <<< 1) + xq + D_ONE;
            state_in = ST_ADD_K1;
         end
         ST_ADD_K1: begin
            p_in     = rnd + k1_ff;
            state_in = ST_MUL_P1;
         end
         ST_MUL_P1: begin
            mul_a    = $signed(p_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(t_ff);
            state_in = ST_ADD_K2;
         end
         ST_ADD_K2: begin
            p_in     = rnd + k2_ff;
            state_in = ST_MUL_P2;
         end
         ST_MUL_P2: begin
            mul_a    = $signed(p_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(t_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (converged) begin
               state_in = ST_Y_TT;
            end else begin
               t_in = $signed(t_clamp[T_W-1:0]);
               if (cnt_ff == LAST_ITER) begin
                  state_in = ST_Y_TT;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_MUL_K0;
               end
            end
         end
         ST_Y_TT: begin
            mul_a    = MUL_A_W'(t_ff);
            mul_b    = MUL_B_W'(t_ff);
            r_in     = $signed(T_W'(ONE_Q24 - t_ext));
            state_in = ST_Y_RR;
         end
         ST_Y_RR: begin
            t2_in    = rnd;
            mul_a    = MUL_A_W'(r_ff);
            mul_b    = MUL_B_W'(r_ff);
            state_in = ST_Y_T2T;
         end
         ST_Y_T2T: begin
            r2_in    = rnd;
            mul_a    = $signed(t2_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(t_ff);
            state_in = ST_Y_T2R;
         end
         ST_Y_T2R: begin
            y_in     = rnd;
            mul_a    = $signed(t2_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(r_ff);
            state_in = ST_Y_BY;
         end
         ST_Y_BY: begin
            mul_a    = $signed(rnd[MUL_A_W-1:0]);
            mul_b    = by3_ff;
            state_in = ST_Y_TR2;
         end
         ST_Y_TR2: begin
            y_in     = y_ff + rnd;
            mul_a    = $signed(r2_ff[MUL_A_W-1:0]);
            mul_b    = MUL_B_W'(t_ff);
            state_in = ST_Y_AY;
         end
         ST_Y_AY: begin
            mul_a    = $signed(rnd[MUL_A_W-1:0]);
            mul_b    = ay3_ff;
            state_in = ST_Y_SUM;
         end
         ST_Y_SUM: begin
            y_in     = y_ff + rnd;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // load the output register once the previous beat is gone
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      diag_ff     <= diag_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ay3_ff      <= ay3_in;
      by3_ff      <= by3_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      p_ff        <= p_in;
      t2_ff       <= t2_in;
      r2_ff       <= r2_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // channel outputs
   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.payload.eased_y = rsp_data_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after a request beat");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= LAST_ITER))
      else $error("round counter past its last round");

   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_K0) |-> ((t_ext <= T_LIMIT_Q24) && (t_ext >= -T_LIMIT_Q24)))
      else $error("curve parameter outside its clamp");

   a_result_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff <= Q15_ONE))
      else $error("response above 1.0");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output step");

endmodule
